[rtl/ovwr_pkg.sv]
// Shared types and constants for the overwriting ring FIFO.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package ovwr_pkg;

  // Fixed field widths of the command and response beats
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FILL_W = 4;
  localparam int unsigned DROP_W = 32;

  // Defaults for the top-level parameters
  localparam int unsigned DEPTH_DEF      = 8;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  localparam logic [DROP_W-1:0] DROP_MAX = {DROP_W{1'b1}};

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  // Per-cell control: take the neighbor's word, or load the pushed word
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic              pop_valid;
    logic [WORD_W-1:0] pop_data;
    logic              drop_flag;
    logic [DROP_W-1:0] drop_total;
    logic [FILL_W-1:0] fill_level;
    logic              is_empty;
    logic              is_full;
  } rsp_item_t;

endpackage

[rtl/ovwr_if.sv]
// Valid/ready channel interfaces for command and response beats.
// Depends on ovwr_pkg.
interface ovwr_req_if;
  logic                         valid;
  logic                         ready;
  ovwr_pkg::cmd_t               command;
  logic [ovwr_pkg::WORD_W-1:0]  push_data;

  modport source(output valid, command, push_data, input ready);
  modport sink(input valid, command, push_data, output ready);
endinterface

interface ovwr_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         pop_valid;
  logic [ovwr_pkg::WORD_W-1:0]  pop_data;
  logic                         drop_flag;
  logic [ovwr_pkg::DROP_W-1:0]  drop_total;
  logic [ovwr_pkg::FILL_W-1:0]  fill_level;
  logic                         is_empty;
  logic                         is_full;

  modport source(output valid, pop_valid, pop_data, drop_flag, drop_total,
                 fill_level, is_empty, is_full, input ready);
  modport sink(input valid, pop_valid, pop_data, drop_flag, drop_total,
               fill_level, is_empty, is_full, output ready);
endinterface

[rtl/ovwr_cell.sv]
// One storage cell of the FIFO chain: holds a word, loads a pushed word or
// takes its right neighbor's word on a shift. Depends on ovwr_pkg.
module ovwr_cell #(
  parameter int unsigned DATA_WIDTH = ovwr_pkg::DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  ovwr_pkg::cell_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0]  push_word,
  input  logic [DATA_WIDTH-1:0]  from_right,
  output logic [DATA_WIDTH-1:0]  word
);

  logic [DATA_WIDTH-1:0] word_next;

  // load wins: a push into a full chain shifts and loads the tail together
  always_comb begin
    if (ctrl.load) begin
      word_next = push_word;
    end else if (ctrl.shift) begin
      word_next = from_right;
    end else begin
      word_next = word;
    end
  end

  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

[rtl/overwrite_ring_fifo_with_drop_count.sv]
// Overwriting FIFO with drop counter, top level. Depends on ovwr_pkg,
// ovwr_if (channel interfaces) and ovwr_cell (storage chain).
//
// DEPTH words are kept in a row of cells, oldest word always in cell 0. A
// command beat is either a push or a pop. A push lands in the first free
// cell; into a full FIFO the whole row shifts toward cell 0, dropping the
// oldest word, and the new word lands in the last cell, the drop flag is
// set and the saturating drop total counts up. A pop returns cell 0 and
// shifts the row; a pop on an empty FIFO returns pop_valid = 0, data zero,
// and changes nothing. Every command gives exactly one response beat that
// also reports fill level, empty and full. Timing: the response appears in
// the cycle after the command is taken, from a registered response stage;
// one command per clock is sustained while the response side keeps up, and
// a command is held off only while a response sits in that register unread.
// Storage has no reset: only occupancy, drop count and the response valid
// flag are cleared, so the block is usable in the first cycle after reset.
module overwrite_ring_fifo_with_drop_count #(
  parameter int unsigned DEPTH      = ovwr_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = ovwr_pkg::DATA_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst,
  ovwr_req_if.sink   req,
  ovwr_rsp_if.source rsp
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned CopyW = (DATA_WIDTH < ovwr_pkg::WORD_W) ?
                                  DATA_WIDTH : ovwr_pkg::WORD_W;

  // fill count and drop counter
  logic [CntW-1:0]             occ, occ_next;
  logic [ovwr_pkg::DROP_W-1:0] drop_cnt, drop_cnt_next;

  // registered response stage
  logic                  rsp_full;
  ovwr_pkg::rsp_item_t   rsp_q, rsp_next;

  logic acc, is_push, fifo_full, push_acc, pop_ok, shift;

  logic [DATA_WIDTH-1:0]       push_word;
  logic [ovwr_pkg::WORD_W-1:0] head_word;
  logic [DATA_WIDTH-1:0]       cell_word [DEPTH];

  assign req.ready = !rsp_full || rsp.ready;
  assign acc       = req.valid && req.ready;
  assign is_push   = (req.command == ovwr_pkg::CMD_PUSH);
  assign fifo_full = (occ == CntW'(DEPTH));
  assign push_acc  = acc && is_push;
  assign pop_ok    = acc && !is_push && (occ != '0);
  // a pop or an overwriting push moves every word one cell toward the head
  assign shift     = pop_ok || (push_acc && fifo_full);

  // fit the 32-bit beat field to the stored width and back
  if (DATA_WIDTH <= ovwr_pkg::WORD_W) begin : g_narrow
    assign push_word = req.push_data[CopyW-1:0];
  end else begin : g_wide
    assign push_word = {{(DATA_WIDTH - ovwr_pkg::WORD_W){1'b0}}, req.push_data};
  end

  if (ovwr_pkg::WORD_W <= DATA_WIDTH) begin : g_head_trunc
    assign head_word = cell_word[0][CopyW-1:0];
  end else begin : g_head_ext
    assign head_word = {{(ovwr_pkg::WORD_W - DATA_WIDTH){1'b0}}, cell_word[0]};
  end

  // storage chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ovwr_pkg::cell_ctrl_t  ctrl;
    logic [DATA_WIDTH-1:0] right;

    // tail cell loads on overwrite; otherwise the first free cell loads
    assign ctrl.shift = shift;
    assign ctrl.load  = push_acc &&
                        ((occ == CntW'(i)) || (fifo_full && (i == DEPTH - 1)));

    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_mid
      assign right = cell_word[i+1];
    end

    ovwr_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .push_word  (push_word),
      .from_right (right),
      .word       (cell_word[i])
    );
  end

  always_comb begin
    occ_next      = occ;
    drop_cnt_next = drop_cnt;
    if (push_acc) begin
      if (fifo_full) begin
        if (drop_cnt != ovwr_pkg::DROP_MAX) begin
          drop_cnt_next = drop_cnt + 1'b1;
        end
      end else begin
        occ_next = occ + 1'b1;
      end
    end else if (pop_ok) begin
      occ_next = occ - 1'b1;
    end

    rsp_next.pop_valid  = pop_ok;
    rsp_next.pop_data   = pop_ok ? head_word : '0;
    rsp_next.drop_flag  = push_acc && fifo_full;
    rsp_next.drop_total = drop_cnt_next;
    rsp_next.fill_level = ovwr_pkg::FILL_W'(occ_next);
    rsp_next.is_empty   = (occ_next == '0);
    rsp_next.is_full    = (occ_next == CntW'(DEPTH));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ      <= '0;
      drop_cnt <= '0;
      rsp_full <= 1'b0;
    end else begin
      occ      <= occ_next;
      drop_cnt <= drop_cnt_next;
      if (acc) begin
        rsp_full <= 1'b1;
      end else if (rsp.ready) begin
        rsp_full <= 1'b0;
      end
    end
  end

  // response payload: loaded only when a command is taken
  always_ff @(posedge clk) begin
    if (acc) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid      = rsp_full;
  assign rsp.pop_valid  = rsp_q.pop_valid;
  assign rsp.pop_data   = rsp_q.pop_data;
  assign rsp.drop_flag  = rsp_q.drop_flag;
  assign rsp.drop_total = rsp_q.drop_total;
  assign rsp.fill_level = rsp_q.fill_level;
  assign rsp.is_empty   = rsp_q.is_empty;
  assign rsp.is_full    = rsp_q.is_full;

`ifndef SYNTHESIS
  // a pop taken on an empty FIFO must answer with no word
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (acc && !is_push && (occ == '0)) |=> (rsp.valid && !rsp.pop_valid))
    else $error("pop on empty FIFO returned a word");

  // a flagged drop leaves the FIFO full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.drop_flag) |-> rsp.is_full)
    else $error("drop reported without a full FIFO");

  // drop total never goes backward outside reset
  a_drop_mono: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (drop_cnt >= $past(drop_cnt)))
    else $error("drop counter decreased");

  // fill count never passes the depth
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    push_acc |=> (occ <= CntW'(DEPTH)))
    else $error("occupancy exceeds depth");
`endif

endmodule

[sim/tb.sv]
// Self-checking bench for overwrite_ring_fifo_with_drop_count: a behavioral ring model
// predicts every response beat, and a scoreboard checks each beat field by field.
// Depends on ovwr_pkg, ovwr_if and the RTL top level.
module tb;

  localparam int unsigned WORD_W      = ovwr_pkg::WORD_W;
  localparam int unsigned DROP_W      = ovwr_pkg::DROP_W;
  localparam int unsigned FILL_W      = ovwr_pkg::FILL_W;
  localparam int unsigned DEPTH       = ovwr_pkg::DEPTH_DEF;
  localparam int unsigned DATA_W      = ovwr_pkg::DATA_WIDTH_DEF;
  // Words wider than the storage lose their high bits on a push
  localparam logic [WORD_W-1:0] KEEP_MASK =
    (DATA_W >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((64'd1 << DATA_W) - 1);
  localparam int unsigned STALL_LIMIT = 2000;  // quiet cycles before giving up
  localparam int unsigned MAX_REPORTS = 10;

  logic clk;
  logic rst;

  ovwr_req_if req ();
  ovwr_rsp_if rsp ();

  overwrite_ring_fifo_with_drop_count #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_W)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // Ring model state: our own copy of storage, pointers, count and drop total
  logic [WORD_W-1:0] ring_slots [DEPTH];
  int unsigned       ring_wr = 0;
  int unsigned       ring_rd = 0;
  int unsigned       ring_count = 0;
  logic [DROP_W-1:0] ring_drops = '0;

  ovwr_pkg::rsp_item_t awaited_rsp [$];  // predicted response beats, oldest first
  int unsigned mismatch_count = 0;
  int unsigned rsp_beats = 0;
  int unsigned quiet_cycles;

  // Traffic shaping knobs, changed by the main sequence between phases
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_len;  // length of the next long ready hold-off
  int unsigned hold_seq;  // bumped to ask the ready driver for a hold-off

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One step of the overwriting ring: returns the response beat a command gives.
  // A push into a full ring drops the oldest word by moving the read pointer on.
  function automatic ovwr_pkg::rsp_item_t ring_step(input ovwr_pkg::cmd_t cmd,
                                                    input logic [WORD_W-1:0] word);
    ovwr_pkg::rsp_item_t r;
    r = '0;
    if (cmd == ovwr_pkg::CMD_PUSH) begin
      if (ring_count >= DEPTH) begin
        r.drop_flag = 1'b1;
        if (ring_drops != ovwr_pkg::DROP_MAX) ring_drops = ring_drops + 1'b1;
        ring_rd = (ring_rd + 1) % DEPTH;
      end else begin
        ring_count++;
      end
      ring_slots[ring_wr] = word & KEEP_MASK;
      ring_wr = (ring_wr + 1) % DEPTH;
    end else if (ring_count != 0) begin
      // pop on empty leaves everything alone and reports pop_valid low
      r.pop_valid = 1'b1;
      r.pop_data  = ring_slots[ring_rd];
      ring_rd = (ring_rd + 1) % DEPTH;
      ring_count--;
    end
    r.drop_total = ring_drops;
    r.fill_level = FILL_W'(ring_count);
    r.is_empty   = (ring_count == 0);
    r.is_full    = (ring_count >= DEPTH);
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [WORD_W-1:0] exp_v,
                               input logic [WORD_W-1:0] act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch on response beat %0d, %s: expected %h, got %h",
               rsp_beats, field, exp_v, act_v);
  endtask

  // Scoreboard. Check comes before predict in the same edge: a response
  // always belongs to a command taken at an earlier edge, so the order is safe.
  always @(posedge clk) begin
    ovwr_pkg::rsp_item_t exp_r;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (awaited_rsp.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("response beat %0d arrived with none expected", rsp_beats);
        end else begin
          exp_r = awaited_rsp.pop_front();
          if (rsp.pop_valid !== exp_r.pop_valid)
            note_mismatch("pop_valid", exp_r.pop_valid, rsp.pop_valid);
          if (rsp.pop_data !== exp_r.pop_data)
            note_mismatch("pop_data", exp_r.pop_data, rsp.pop_data);
          if (rsp.drop_flag !== exp_r.drop_flag)
            note_mismatch("drop_flag", exp_r.drop_flag, rsp.drop_flag);
          if (rsp.drop_total !== exp_r.drop_total)
            note_mismatch("drop_total", exp_r.drop_total, rsp.drop_total);
          if (rsp.fill_level !== exp_r.fill_level)
            note_mismatch("fill_level", exp_r.fill_level, rsp.fill_level);
          if (rsp.is_empty !== exp_r.is_empty)
            note_mismatch("is_empty", exp_r.is_empty, rsp.is_empty);
          if (rsp.is_full !== exp_r.is_full)
            note_mismatch("is_full", exp_r.is_full, rsp.is_full);
        end
        rsp_beats++;
      end
      if (req.valid && req.ready)
        awaited_rsp.push_back(ring_step(req.command, req.push_data));
    end
  end

  // Watchdog: any cycle without a beat on either channel counts toward the limit
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Response-side ready. A hold-off request is picked up here and counted down
  // in this process, so the sender can keep offering beats meanwhile.
  initial begin : rsp_ready_gen
    int unsigned hold_left;
    int unsigned hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != hold_seen) begin
        hold_left = hold_len;
        hold_seen = hold_seq;
      end
      if (hold_left != 0) begin
        rsp.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one command beat, with random idle gaps ahead of it. Called and
  // returns at a falling edge. Valid stays up for back-to-back beats.
  task automatic send_beat(input ovwr_pkg::cmd_t cmd, input logic [WORD_W-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid     <= 1'b1;
    req.command   <= cmd;
    req.push_data <= word;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  // Stop offering and wait for every predicted response to come back
  task automatic wait_drained(input int unsigned settle);
    req.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // Corners: pop on empty, data extremes, filling up, overwrite on full with
  // wrap of the pointers, full drain, pop on empty again, pop data ignored.
  task automatic test_directed();
    send_beat(ovwr_pkg::CMD_POP, $urandom);
    send_beat(ovwr_pkg::CMD_PUSH, 32'h0000_0000);
    send_beat(ovwr_pkg::CMD_PUSH, 32'hFFFF_FFFF);
    send_beat(ovwr_pkg::CMD_PUSH, 32'hAAAA_AAAA);
    send_beat(ovwr_pkg::CMD_PUSH, 32'h5555_5555);
    send_beat(ovwr_pkg::CMD_PUSH, 32'h0000_0001);
    send_beat(ovwr_pkg::CMD_PUSH, 32'h8000_0000);
    send_beat(ovwr_pkg::CMD_PUSH, $urandom);
    send_beat(ovwr_pkg::CMD_PUSH, $urandom);      // ring now full
    repeat (3) send_beat(ovwr_pkg::CMD_PUSH, $urandom);  // each one drops the oldest
    repeat (DEPTH) send_beat(ovwr_pkg::CMD_POP, 32'hFFFF_FFFF);
    send_beat(ovwr_pkg::CMD_POP, 32'h0000_0000);  // empty again
    send_beat(ovwr_pkg::CMD_PUSH, 32'h1234_5678);
    send_beat(ovwr_pkg::CMD_POP, $urandom);
    wait_drained(4);
  endtask

  // Runs of mostly pushes push the ring into overwrite; runs of mostly pops
  // walk it down to empty and past it. The bias changes every couple dozen beats.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned push_pct;
    logic [WORD_W-1:0] word;
    push_pct = 50;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 24 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 85;
        endcase
      end
      case ($urandom_range(7))
        0: word = '0;
        1: word = '1;
        default: word = $urandom;
      endcase
      send_beat(($urandom_range(99) < push_pct) ? ovwr_pkg::CMD_PUSH : ovwr_pkg::CMD_POP,
                word);
    end
    wait_drained(4);
  endtask

  // Long response hold-off while commands keep coming: the output register
  // fills and the block must stall its command side without losing a beat.
  task automatic test_response_stall();
    hold_len = 80;
    hold_seq++;
    repeat (30)
      send_beat(($urandom_range(3) != 0) ? ovwr_pkg::CMD_PUSH : ovwr_pkg::CMD_POP,
                $urandom);
    wait_drained(4);
  endtask

  // Sender goes quiet until every response is home, then resumes
  task automatic test_sender_pause();
    repeat (12)
      send_beat(($urandom_range(1) != 0) ? ovwr_pkg::CMD_PUSH : ovwr_pkg::CMD_POP,
                $urandom);
    wait_drained(2);
    repeat (12)
      send_beat(($urandom_range(1) != 0) ? ovwr_pkg::CMD_POP : ovwr_pkg::CMD_PUSH,
                $urandom);
    wait_drained(2);
  endtask

  initial begin
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.command    = ovwr_pkg::CMD_PUSH;
    req.push_data  = '0;
    send_idle_pct  = 8;
    recv_idle_pct  = 63;
    hold_len       = 0;
    hold_seq       = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // slow receiver
    test_directed();
    test_random_traffic(560);

    // slow sender
    send_idle_pct = 63;
    recv_idle_pct = 8;
    test_random_traffic(560);
    test_sender_pause();

    // no idling either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_response_stall();
    test_random_traffic(560);

    wait_drained(8);
    if (mismatch_count == 0 && awaited_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
